// File: rtl/pidl_pkg.sv
// Package for the positional insert/delete list unit.
// Holds the shared constants, operation and status codes, and the cell command type.
// No dependencies.
`default_nettype none

package pidl_pkg;

   localparam int PIDL_DEPTH     = 64;   // default number of list cells
   localparam int PIDL_CAP_RESET = 64;   // capacity after reset, before clamping to the depth
   localparam int PIDL_WORD_W    = 32;
   localparam int PIDL_CNT_W     = 7;
   localparam int PIDL_OP_W      = 2;
   localparam int PIDL_ST_W      = 2;
   localparam int PIDL_GROUP     = 32;   // cells combined by one node of the read tree

   typedef enum logic [PIDL_OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_APPEND = 2'd1,
      OP_DELETE = 2'd2,
      OP_READ   = 2'd3
   } pidl_op_type;

   typedef enum logic [PIDL_ST_W-1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_OVERFLOW = 2'd2
   } pidl_status_type;

   // Command broadcast to every cell in the cycle an item is accepted.
   typedef struct packed {
      logic                   ins;    // open a slot and write value there
      logic                   del;    // close the slot, later cells move down
      logic                   rd;     // the slot drives its word onto the read tree
      logic [PIDL_CNT_W-1:0]  slot;   // 0-based cell index of the operation
      logic [PIDL_WORD_W-1:0] value;
   } pidl_cmd_type;

endpackage

`default_nettype wire

// File: rtl/pidl_cell.sv
// One list cell: holds a single entry and trades it with its neighbors.
// Depends on pidl_pkg for the command type.
`default_nettype none

module pidl_cell import pidl_pkg::*; #(
   parameter int INDEX = 0
) (
   input  wire logic                   clock,
   input  wire pidl_cmd_type           cmd,
   input  wire logic [PIDL_WORD_W-1:0] left_word,   // word of the cell below
   input  wire logic [PIDL_WORD_W-1:0] right_word,  // word of the cell above
   output logic      [PIDL_WORD_W-1:0] word_out,
   output logic      [PIDL_WORD_W-1:0] read_word
);

   logic [PIDL_WORD_W-1:0] word_ff;
   logic [PIDL_WORD_W-1:0] word_in;
   logic                   at_slot;
   logic                   above_slot;

   assign at_slot    = (32'(cmd.slot) == 32'(INDEX));
   assign above_slot = (32'(INDEX) > 32'(cmd.slot));

   always_comb begin
      word_in = word_ff;
      if (cmd.ins && above_slot) begin
         word_in = left_word;
      end else if (cmd.ins && at_slot) begin
         word_in = cmd.value;
      end else if (cmd.del && (above_slot || at_slot)) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out  = word_ff;
   assign read_word = (cmd.rd && at_slot) ? word_ff : '0;

endmodule

`default_nettype wire

// File: rtl/pidl_rsp_pipe.sv
// Result pipeline: a two-level registered OR tree over the cell read words,
// carrying status and count alongside, with the output register at the end.
// Depends on pidl_pkg.
`default_nettype none

module pidl_rsp_pipe import pidl_pkg::*; #(
   parameter int DEPTH = PIDL_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire logic [PIDL_ST_W-1:0]               in_status,
   input  wire logic [PIDL_CNT_W-1:0]              in_count,
   input  wire logic [DEPTH-1:0][PIDL_WORD_W-1:0]  in_words,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [PIDL_ST_W-1:0]               rsp_status,
   output logic      [PIDL_CNT_W-1:0]              rsp_count,
   output logic signed [PIDL_WORD_W-1:0]           rsp_read_value
);

   localparam int NGRP = (DEPTH + PIDL_GROUP - 1) / PIDL_GROUP;

   logic [NGRP*PIDL_GROUP-1:0][PIDL_WORD_W-1:0] padded;
   logic [NGRP-1:0][PIDL_WORD_W-1:0]            grp_or;
   logic [PIDL_WORD_W-1:0]                      final_or;

   logic                                        s1_valid_ff;
   logic [PIDL_ST_W-1:0]                        s1_status_ff;
   logic [PIDL_CNT_W-1:0]                       s1_count_ff;
   logic [NGRP-1:0][PIDL_WORD_W-1:0]            s1_grp_ff;

   logic                                        out_valid_ff;
   logic [PIDL_ST_W-1:0]                        out_status_ff;
   logic [PIDL_CNT_W-1:0]                       out_count_ff;
   logic [PIDL_WORD_W-1:0]                      out_word_ff;

   logic                                        out_en;
   logic                                        s1_en;

   assign padded = (NGRP*PIDL_GROUP*PIDL_WORD_W)'(in_words);

   // At most one cell drives a nonzero word, so OR acts as the select.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_or[g] = '0;
         for (int j = 0; j < PIDL_GROUP; j++) begin
            grp_or[g] = grp_or[g] | padded[g*PIDL_GROUP + j];
         end
      end
   end

   always_comb begin
      final_or = '0;
      for (int g = 0; g < NGRP; g++) begin
         final_or = final_or | s1_grp_ff[g];
      end
   end

   // Each stage moves when the one after it is empty or moving.
   assign out_en   = !out_valid_ff || rsp_ready;
   assign s1_en    = !s1_valid_ff || out_en;
   assign in_ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= in_valid;
         end
         if (out_en) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && in_valid) begin
         s1_status_ff <= in_status;
         s1_count_ff  <= in_count;
         s1_grp_ff    <= grp_or;
      end
      if (out_en && s1_valid_ff) begin
         out_status_ff <= s1_status_ff;
         out_count_ff  <= s1_count_ff;
         out_word_ff   <= final_or;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_count      = out_count_ff;
   assign rsp_read_value = $signed(out_word_ff);

endmodule

`default_nettype wire

// File: rtl/positional_insert_delete_list_unit.sv
// Top level of the positional insert/delete list unit.
// Depends on pidl_pkg, pidl_cell and pidl_rsp_pipe.
`default_nettype none

// Keeps a dense ordered list of signed 32-bit words in a row of DEPTH cells.
// Each item is one operation (insert at a 1-based position, append, delete at a
// position, read at a position) and yields exactly one result with status,
// entry count after the operation, and the word read (0 unless a read succeeds).
// All cells shift in the cycle an item is accepted, so one item is taken every
// clock cycle while the result pipeline is not stalled; each result passes through
// the two registered levels of the read tree that collect the selected cell (the
// first level loads on the accepting edge, the second is the output register).
// A stalled result holds the pipeline only once both stages are full.
// Writing the capacity register (clamped to DEPTH) empties the list; the user
// must write the register only while no item is in flight, which the block itself
// does not enforce. Capacity resets to 64, clamped to DEPTH.

module positional_insert_delete_list_unit import pidl_pkg::*; #(
   parameter int DEPTH = PIDL_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [PIDL_OP_W-1:0]         req_operation,
   input  wire logic signed [PIDL_WORD_W-1:0] req_value,
   input  wire logic [PIDL_CNT_W-1:0]        req_position,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [PIDL_ST_W-1:0]         rsp_status,
   output logic      [PIDL_CNT_W-1:0]        rsp_count,
   output logic signed [PIDL_WORD_W-1:0]     rsp_read_value,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [PIDL_CNT_W-1:0]        csr_capacity
);

   localparam logic [PIDL_CNT_W-1:0] CAP_RESET =
      (DEPTH < PIDL_CAP_RESET) ? PIDL_CNT_W'(DEPTH) : PIDL_CNT_W'(PIDL_CAP_RESET);

   logic [PIDL_CNT_W-1:0]                capacity_ff;
   logic [PIDL_CNT_W-1:0]                capacity_in;
   logic [PIDL_CNT_W-1:0]                fill_ff;
   logic [PIDL_CNT_W-1:0]                fill_in;
   logic [PIDL_CNT_W-1:0]                fill_after;

   logic                                 accept;
   logic                                 csr_write;
   pidl_op_type                          op;
   pidl_status_type                      status;
   pidl_cmd_type                         cmd;
   logic                                 do_ins;
   logic                                 do_del;
   logic                                 do_rd;
   logic [PIDL_CNT_W-1:0]                slot;
   logic                                 ins_pos_ok;
   logic                                 pos_ok;
   logic                                 full;

   logic [DEPTH-1:0][PIDL_WORD_W-1:0]    cell_words;
   logic [DEPTH-1:0][PIDL_WORD_W-1:0]    cell_reads;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign accept    = req_valid && req_ready;
   assign op        = pidl_op_type'(req_operation);

   assign ins_pos_ok = (req_position != '0) &&
                       ({1'b0, req_position} <= ({1'b0, fill_ff} + (PIDL_CNT_W+1)'(1)));
   assign pos_ok     = (req_position != '0) && (req_position <= fill_ff);
   assign full       = (fill_ff >= capacity_ff);

   always_comb begin
      status     = ST_OK;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      do_rd      = 1'b0;
      slot       = req_position - PIDL_CNT_W'(1);
      fill_after = fill_ff;
      case (op)
         OP_INSERT: begin
            if (!ins_pos_ok) begin
               status = ST_INVALID;
            end else if (full) begin
               status = ST_OVERFLOW;
            end else begin
               do_ins     = 1'b1;
               fill_after = fill_ff + PIDL_CNT_W'(1);
            end
         end
         OP_APPEND: begin
            slot = fill_ff;
            if (full) begin
               status = ST_OVERFLOW;
            end else begin
               do_ins     = 1'b1;
               fill_after = fill_ff + PIDL_CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (!pos_ok) begin
               status = ST_INVALID;
            end else begin
               do_del     = 1'b1;
               fill_after = fill_ff - PIDL_CNT_W'(1);
            end
         end
         OP_READ: begin
            if (!pos_ok) begin
               status = ST_INVALID;
            end else begin
               do_rd = 1'b1;
            end
         end
         default: begin
            status = ST_INVALID;
         end
      endcase
   end

   assign cmd.ins   = accept && do_ins;
   assign cmd.del   = accept && do_del;
   assign cmd.rd    = accept && do_rd;
   assign cmd.slot  = slot;
   assign cmd.value = $unsigned(req_value);

   always_comb begin
      capacity_in = capacity_ff;
      fill_in     = fill_ff;
      if (csr_write) begin
         capacity_in = (32'(csr_capacity) > 32'(DEPTH)) ? PIDL_CNT_W'(DEPTH) : csr_capacity;
         fill_in     = '0;
      end else if (accept) begin
         fill_in = fill_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         fill_ff     <= '0;
      end else begin
         capacity_ff <= capacity_in;
         fill_ff     <= fill_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [PIDL_WORD_W-1:0] left_word;
      logic [PIDL_WORD_W-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_inner_left
         assign left_word = cell_words[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner_right
         assign right_word = cell_words[i+1];
      end

      pidl_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_word  (left_word),
         .right_word (right_word),
         .word_out   (cell_words[i]),
         .read_word  (cell_reads[i])
      );
   end

   pidl_rsp_pipe #(
      .DEPTH (DEPTH)
   ) u_rsp_pipe (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .in_ready       (req_ready),
      .in_status      (status),
      .in_count       (fill_after),
      .in_words       (cell_reads),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_read_value (rsp_read_value)
   );

endmodule

`default_nettype wire

// File: rtl/pidl_checker.sv
// Port-level checks for the positional insert/delete list unit, bound to the top level.
// Depends on pidl_pkg and positional_insert_delete_list_unit.
`default_nettype none

module pidl_checker import pidl_pkg::*; #(
   parameter int DEPTH = PIDL_DEPTH
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [PIDL_ST_W-1:0]          rsp_status,
   input wire logic [PIDL_CNT_W-1:0]         rsp_count,
   input wire logic signed [PIDL_WORD_W-1:0] rsp_read_value
);

   // No result may appear in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   // A failed operation reports a zero read word.
   a_fail_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_read_value == '0))
      else $error("failed item carries a nonzero read word");

   // The entry count never goes past the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_count) <= 32'(DEPTH)))
      else $error("entry count beyond list depth");

   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_read_value)))
      else $error("stalled result changed");

endmodule

bind positional_insert_delete_list_unit pidl_checker #(
   .DEPTH (DEPTH)
) u_pidl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_count      (rsp_count),
   .rsp_read_value (rsp_read_value)
);

`default_nettype wire
